[hw/rtl/r5alloc_pkg.sv]
`default_nettype none

package r5alloc_pkg;

    localparam int MAX_DISKS   = 8;
    localparam int DISK_W      = $clog2(MAX_DISKS);
    localparam int N_W         = $clog2(MAX_DISKS + 1);
    localparam int NCNT_W      = 4;
    localparam int BLK_W       = 24;
    localparam int REQ_W       = 16;
    localparam int CHUNK_W     = 8;
    localparam int NUM_CHUNKS  = BLK_W / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = BLK_W;

    localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = CFG_IDX_W'(1);

    localparam logic [NCNT_W-1:0] RESET_DISK_COUNT = NCNT_W'(4);
    localparam logic [NCNT_W-1:0] MIN_DISK_COUNT   = NCNT_W'(2);
    localparam logic [BLK_W-1:0]  RESET_CAPACITY   = {BLK_W{1'b1}};

    typedef struct packed {
        logic                   load;
        logic                   mod_en;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic                   eval;
        logic                   finish;
        logic [DISK_W-1:0]      disk;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [N_W-1:0] n_active;
        logic           out_free;
    } dp_status_t;

    // Fold one chunk of an offset into a running residue modulo n, one bit a step.
    function automatic logic [DISK_W-1:0] mod_step(
        input logic [DISK_W-1:0]  r,
        input logic [CHUNK_W-1:0] bits,
        input logic [N_W-1:0]     n
    );
        logic [DISK_W:0]   t;
        logic [DISK_W-1:0] acc;
        acc = r;
        for (int k = CHUNK_W - 1; k >= 0; k--)
        begin
            t = {acc, bits[k]};
            if (t >= (DISK_W + 1)'(n))
            begin
                t = t - (DISK_W + 1)'(n);
            end
            acc = t[DISK_W-1:0];
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/r5alloc_if.sv]
`default_nettype none

interface r5alloc_req_if;
    import r5alloc_pkg::*;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] block_count;
    modport source (output valid, output block_count, input ready);
    modport sink (input valid, input block_count, output ready);
endinterface

interface r5alloc_rsp_if;
    import r5alloc_pkg::*;
    logic              valid;
    logic              ready;
    logic              granted;
    logic [DISK_W-1:0] data_disk;
    logic [BLK_W-1:0]  start_block;
    logic [DISK_W-1:0] parity_disk;
    modport source (output valid, output granted, output data_disk, output start_block,
                    output parity_disk, input ready);
    modport sink (input valid, input granted, input data_disk, input start_block,
                  input parity_disk, output ready);
endinterface

interface r5alloc_cfg_if;
    import r5alloc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/raid5_stripe_block_allocator.sv]
`default_nettype none

// RAID-5 stripe block allocator. Each request on req names a block count and yields
// exactly one response on rsp: the granted flag, the data disk, the first block and
// the stripe's parity disk (all zero when no disk has room). Per-disk next-free
// offsets reset to zero. For each of the N active disks (N is 2..8), the offset goes
// chunk by chunk through the shared residue unit, which folds eight offset bits per
// cycle modulo N, and an evaluate step then does the parity skip and the best-disk
// compare; the result waits for a free output register. One request is in
// flight at a time; a new one is accepted while the previous response still waits
// in the output register. Write cfg only while no request is in flight.
module raid5_stripe_block_allocator
    import r5alloc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    r5alloc_req_if.sink   req,
    r5alloc_rsp_if.source rsp,
    r5alloc_cfg_if.sink   cfg
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    r5alloc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    r5alloc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .block_count (req.block_count),
        .cfg         (cfg),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

[hw/rtl/r5alloc_ctrl.sv]
`default_nettype none

module r5alloc_ctrl
    import r5alloc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MOD    = 2'd1;
    localparam logic [1:0] ST_EVAL   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [DISK_W-1:0]      disk_reg, disk_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic                   last_disk;
    logic                   last_chunk;

    assign last_disk  = N_W'(disk_reg) == (status.n_active - N_W'(1));
    assign last_chunk = chunk_reg == CHUNK_IDX_W'(NUM_CHUNKS - 1);
    assign req_ready  = state_reg == ST_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        disk_next    = disk_reg;
        chunk_next   = chunk_reg;
        cmd.load     = 1'b0;
        cmd.mod_en   = 1'b0;
        cmd.eval     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.chunk    = chunk_reg;
        cmd.disk     = disk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    disk_next  = '0;
                    chunk_next = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_en = 1'b1;
                if (last_chunk)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    chunk_next = chunk_reg + CHUNK_IDX_W'(1);
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (last_disk)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    disk_next  = disk_reg + DISK_W'(1);
                    chunk_next = '0;
                    state_next = ST_MOD;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            disk_reg  <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            disk_reg  <= disk_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/r5alloc_dp.sv]
`default_nettype none

module r5alloc_dp
    import r5alloc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  logic [REQ_W-1:0] block_count,
    r5alloc_cfg_if.sink      cfg,
    r5alloc_rsp_if.source    rsp
);

    logic [NCNT_W-1:0] disk_count_reg;
    logic [BLK_W-1:0]  capacity_reg;
    logic [BLK_W-1:0]  offset_reg [MAX_DISKS];
    logic [REQ_W-1:0]  req_reg;
    logic [DISK_W-1:0] resid_reg, resid_next;
    logic [BLK_W-1:0]  best_off_reg;
    logic [DISK_W-1:0] best_mod_reg;
    logic [DISK_W-1:0] chosen_reg;
    logic              found_reg;
    logic              out_valid_reg;
    logic              granted_reg;
    logic [DISK_W-1:0] data_disk_reg;
    logic [BLK_W-1:0]  start_block_reg;
    logic [DISK_W-1:0] parity_disk_reg;

    logic [N_W-1:0]    n_active;
    logic [BLK_W-1:0]  cur_off;
    logic [DISK_W-1:0] mod_in;
    logic [N_W-1:0]    parity_pos;
    logic              skip;
    logic [BLK_W-1:0]  off_new;
    logic [N_W-1:0]    mod_inc;
    logic [DISK_W-1:0] mod_new;
    logic [BLK_W-1:0]  room;
    logic              fits;
    logic              take;

    always_comb
    begin
        if (disk_count_reg < MIN_DISK_COUNT)
        begin
            n_active = N_W'(MIN_DISK_COUNT);
        end
        else if (disk_count_reg > NCNT_W'(MAX_DISKS))
        begin
            n_active = N_W'(MAX_DISKS);
        end
        else
        begin
            n_active = N_W'(disk_count_reg);
        end
    end

    assign cur_off    = offset_reg[cmd.disk];
    assign mod_in     = (cmd.chunk == '0) ? '0 : resid_reg;
    assign resid_next = mod_step(mod_in,
                                 cur_off[(NUM_CHUNKS - 1 - int'(cmd.chunk)) * CHUNK_W +: CHUNK_W],
                                 n_active);

    // skip the parity block sitting at this disk's next offset
    assign parity_pos = n_active - N_W'(1) - N_W'(resid_reg);
    assign skip       = (N_W'(cmd.disk) == parity_pos) && (cur_off < capacity_reg);
    assign off_new    = skip ? cur_off + BLK_W'(1) : cur_off;
    assign mod_inc    = N_W'(resid_reg) + N_W'(1);
    assign mod_new    = skip ? ((mod_inc == n_active) ? '0 : DISK_W'(mod_inc)) : resid_reg;
    assign room       = (off_new >= capacity_reg) ? '0 : capacity_reg - off_new;
    assign fits       = BLK_W'(req_reg) <= room;
    assign take       = (cmd.disk == '0) ||
                        (fits && (found_reg ? (off_new < best_off_reg)
                                            : (off_new <= best_off_reg)));

    assign status.n_active = n_active;
    assign status.out_free = !out_valid_reg || rsp.ready;

    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.granted     = granted_reg;
    assign rsp.data_disk   = data_disk_reg;
    assign rsp.start_block = start_block_reg;
    assign rsp.parity_disk = parity_disk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_count_reg <= RESET_DISK_COUNT;
            capacity_reg   <= RESET_CAPACITY;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_DISKS; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_DISK_COUNT: disk_count_reg <= cfg.data[NCNT_W-1:0];
                    REG_CAPACITY:   capacity_reg   <= cfg.data[BLK_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.eval)
            begin
                offset_reg[cmd.disk] <= off_new;
            end
            // advance the chosen disk past the granted blocks
            if (cmd.finish && found_reg)
            begin
                offset_reg[chosen_reg] <= best_off_reg + BLK_W'(req_reg);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= block_count;
        end
        if (cmd.mod_en)
        begin
            resid_reg <= resid_next;
        end
        if (cmd.eval && take)
        begin
            best_off_reg <= off_new;
            best_mod_reg <= mod_new;
            chosen_reg   <= cmd.disk;
        end
        if (cmd.eval)
        begin
            if (cmd.disk == '0)
            begin
                found_reg <= fits;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            granted_reg <= found_reg;
            if (found_reg)
            begin
                data_disk_reg   <= chosen_reg;
                start_block_reg <= best_off_reg;
                parity_disk_reg <= DISK_W'(n_active - N_W'(1) - N_W'(best_mod_reg));
            end
            else
            begin
                data_disk_reg   <= '0;
                start_block_reg <= '0;
                parity_disk_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/r5alloc_chk.sv]
`default_nettype none

module r5alloc_chk
    import r5alloc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              granted,
    input wire logic [DISK_W-1:0] data_disk,
    input wire logic [BLK_W-1:0]  start_block,
    input wire logic [DISK_W-1:0] parity_disk
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted) && $stable(data_disk)
                                    && $stable(start_block) && $stable(parity_disk))
        else $error("response changed while stalled");

    a_rsp_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(rsp_ready))
        else $error("response dropped without being taken");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !granted |-> data_disk == '0 && start_block == '0 && parity_disk == '0)
        else $error("failed response carries nonzero fields");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_valid && req_ready))
        else $error("response appeared one cycle after a request");

endmodule

bind raid5_stripe_block_allocator r5alloc_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .granted     (rsp.granted),
    .data_disk   (rsp.data_disk),
    .start_block (rsp.start_block),
    .parity_disk (rsp.parity_disk)
);

`default_nettype wire
